// ===== hw/rtl/gcd_pkg.sv =====
// Shared constants, types and arithmetic helpers for the great-circle distance pipeline.
`timescale 1ns / 1ps

package gcd_pkg;

    // CORDIC
    localparam int STEPS         = 28;
    localparam int CORDIC_SPS    = 4;
    localparam int CORDIC_STAGES = (STEPS + CORDIC_SPS - 1) / CORDIC_SPS;
    localparam int CW            = 34;   // CORDIC word: x, y, z
    localparam int AW            = 35;   // angle word before wrap

    // square root
    localparam int SQRT_IN_W   = 61;
    localparam int ROOT_W      = 31;
    localparam int RES_W       = 63;
    localparam int SQRT_ITERS  = 31;
    localparam int SQRT_SPS    = 4;
    localparam int SQRT_STAGES = (SQRT_ITERS + SQRT_SPS - 1) / SQRT_SPS;

    localparam int A_W    = 31;          // clamped haversine term, Q30
    localparam int DIST_W = 25;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [AW-1:0] FULL_TURN = 35'sd6039797760;
    localparam logic signed [AW-1:0] HALF_TURN = 35'sd3019898880;
    localparam logic signed [AW-1:0] QUARTER   = 35'sd1509949440;
    localparam logic [A_W-1:0]       Q_ONE     = 31'd1073741824;
    localparam logic [29:0]          ARC_SCALE = 30'd910908839;
    localparam logic [DIST_W-1:0]    MAX_DIST  = 25'd20015087;

    // atan(2^-i) in degrees * 2^24
    localparam logic [29:0] ARC_TABLE [STEPS] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
        30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
        30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
        30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
        30'd29,        30'd14,        30'd7
    };

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic                 neg;   // cosine must be negated
    } fold_t;

    // wrap to [-180, 180) and fold into [-90, 90]; input stays within +/- 2^32
    function automatic fold_t wrap_fold(input logic signed [AW-1:0] ang);
        logic signed [AW-1:0] r;
        fold_t f;
        r = ang;
        if (r >= HALF_TURN) begin
            r = r - FULL_TURN;
        end else if (r < -HALF_TURN) begin
            r = r + FULL_TURN;
        end
        f.neg = 1'b0;
        if (r > QUARTER) begin
            r = HALF_TURN - r;
            f.neg = 1'b1;
        end else if (r < -QUARTER) begin
            r = -HALF_TURN - r;
            f.neg = 1'b1;
        end
        f.z = r[CW-1:0];
        return f;
    endfunction

    // Q30 product, rounded with ties toward plus infinity
    function automatic logic signed [32:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return p[62:30];
    endfunction

endpackage

// ===== hw/rtl/great_circle_distance.sv =====
// Top level: pipelined haversine great-circle distance between two coordinate pairs.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one transaction carries both points, latitude and
//   longitude in signed degrees with 16 fraction bits. Output channel m_*:
//   one transaction per input, the distance in whole meters, rounded and
//   saturated at half the circumference of a 6371 km sphere.
// Throughput: one transaction per cycle, sustained while the output is not stalled.
//   Each stage holds at most four CORDIC or square-root iterations, or one multiply.
// Pipeline: 28 register stages, made up of 1 angle-fold stage, 7 sine/cosine
//   CORDIC stages, 3 multiply/clamp stages, 8 square-root stages, 7 arc-tangent
//   CORDIC stages and 2 scaling stages (the last one is the output register).
// Stall: one enable moves the whole pipe. While m_tvalid is high and
//   m_tready low everything holds and s_tready is low; nothing is lost
//   or repeated. Bubbles stay where they are.
// Reset: aresetn (synchronous, active low) clears every valid bit; data
//   registers are not reset. No configuration and no state between items.

module great_circle_distance (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [23:0] first_latitude, [48:24] first_longitude,
    // [72:49] second_latitude, [97:73] second_longitude, [103:98] zero
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [24:0] distance_meters, [31:25] zero
    output logic [31:0]  m_tdata
);

    localparam int CW    = gcd_pkg::CW;
    localparam int AW    = gcd_pkg::AW;
    localparam int CS    = gcd_pkg::CORDIC_STAGES;
    localparam int LAT   = 2 * CS + gcd_pkg::SQRT_STAGES + 6;
    localparam int A_IDX = CS + 3;   // valid bit that pairs with a_reg

    logic           en;
    logic [LAT-1:0] vld_reg;

    // whole pipe advances unless the output register is full and stalled
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ---------------- stage 0: angles, wrap and fold ----------------
    logic signed [23:0] lat1, lat2;
    logic signed [24:0] lon1, lon2;
    logic signed [24:0] dlat;
    logic signed [25:0] dlon;
    gcd_pkg::fold_t     f_dlat, f_dlon, f_lat1, f_lat2;

    assign lat1 = $signed(s_tdata[23:0]);
    assign lon1 = $signed(s_tdata[48:24]);
    assign lat2 = $signed(s_tdata[72:49]);
    assign lon2 = $signed(s_tdata[97:73]);
    assign dlat = 25'(lat2) - 25'(lat1);
    assign dlon = 26'(lon2) - 26'(lon1);

    // half differences scale by 2^7, latitudes by 2^8 into degrees * 2^24
    assign f_dlat = gcd_pkg::wrap_fold(AW'(dlat) <<< 7);
    assign f_dlon = gcd_pkg::wrap_fold(AW'(dlon) <<< 7);
    assign f_lat1 = gcd_pkg::wrap_fold(AW'(lat1) <<< 8);
    assign f_lat2 = gcd_pkg::wrap_fold(AW'(lat2) <<< 8);

    logic signed [CW-1:0] z_dlat_reg, z_dlon_reg, z_lat1_reg, z_lat2_reg;
    logic                 neg1_reg, neg2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            z_dlat_reg <= f_dlat.z;
            z_dlon_reg <= f_dlon.z;
            z_lat1_reg <= f_lat1.z;
            z_lat2_reg <= f_lat2.z;
            neg1_reg   <= f_lat1.neg;
            neg2_reg   <= f_lat2.neg;
        end
    end

    // ---------------- sine / cosine CORDICs ----------------
    logic signed [CW-1:0] s_lat, s_lon, x_lat1, x_lat2;
    logic                 neg1_d, neg2_d;

    gcd_cordic #(.VECTORING(1'b0)) u_sin_dlat (
        .aclk(aclk), .en(en),
        .x_in(gcd_pkg::GAIN_Q30), .y_in('0), .z_in(z_dlat_reg), .tag_in(1'b0),
        .x_out(), .y_out(s_lat), .z_out(), .tag_out()
    );

    gcd_cordic #(.VECTORING(1'b0)) u_sin_dlon (
        .aclk(aclk), .en(en),
        .x_in(gcd_pkg::GAIN_Q30), .y_in('0), .z_in(z_dlon_reg), .tag_in(1'b0),
        .x_out(), .y_out(s_lon), .z_out(), .tag_out()
    );

    gcd_cordic #(.VECTORING(1'b0)) u_cos_lat1 (
        .aclk(aclk), .en(en),
        .x_in(gcd_pkg::GAIN_Q30), .y_in('0), .z_in(z_lat1_reg), .tag_in(neg1_reg),
        .x_out(x_lat1), .y_out(), .z_out(), .tag_out(neg1_d)
    );

    gcd_cordic #(.VECTORING(1'b0)) u_cos_lat2 (
        .aclk(aclk), .en(en),
        .x_in(gcd_pkg::GAIN_Q30), .y_in('0), .z_in(z_lat2_reg), .tag_in(neg2_reg),
        .x_out(x_lat2), .y_out(), .z_out(), .tag_out(neg2_d)
    );

    // ---------------- haversine term ----------------
    logic signed [CW-1:0] c1, c2;
    assign c1 = neg1_d ? -x_lat1 : x_lat1;
    assign c2 = neg2_d ? -x_lat2 : x_lat2;

    // CORDIC outputs stay within +/- 2^31, so 32 bits carry them exactly
    logic signed [32:0] p_lat_reg, p_c_reg, p_lon_reg;
    logic signed [32:0] p_lat2_reg, p_h_reg;
    logic [gcd_pkg::A_W-1:0] a_reg;
    logic signed [33:0]      a_sum;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_lat_reg <= gcd_pkg::qmul(s_lat[31:0], s_lat[31:0]);
            p_c_reg   <= gcd_pkg::qmul(c1[31:0], c2[31:0]);
            p_lon_reg <= gcd_pkg::qmul(s_lon[31:0], s_lon[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_lat2_reg <= p_lat_reg;
            p_h_reg    <= gcd_pkg::qmul(p_c_reg[31:0], p_lon_reg[31:0]);
        end
    end

    assign a_sum = 34'(p_lat2_reg) + 34'(p_h_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (a_sum < 0) begin
                a_reg <= '0;
            end else if (a_sum > $signed(34'(gcd_pkg::Q_ONE))) begin
                a_reg <= gcd_pkg::Q_ONE;
            end else begin
                a_reg <= a_sum[gcd_pkg::A_W-1:0];
            end
        end
    end

    // ---------------- square roots ----------------
    logic [gcd_pkg::SQRT_IN_W-1:0] v_cos, v_sin;
    logic [gcd_pkg::ROOT_W-1:0]    root_cos, root_sin;

    assign v_cos = {gcd_pkg::Q_ONE - a_reg, 30'd0};
    assign v_sin = {a_reg, 30'd0};

    gcd_isqrt u_sqrt_cos (.aclk(aclk), .en(en), .v_in(v_cos), .root_out(root_cos));
    gcd_isqrt u_sqrt_sin (.aclk(aclk), .en(en), .v_in(v_sin), .root_out(root_sin));

    // ---------------- arc tangent ----------------
    logic signed [CW-1:0] theta;

    gcd_cordic #(.VECTORING(1'b1)) u_atan (
        .aclk(aclk), .en(en),
        .x_in($signed(CW'(root_cos))), .y_in($signed(CW'(root_sin))), .z_in('0),
        .tag_in(1'b0),
        .x_out(), .y_out(), .z_out(theta), .tag_out()
    );

    // ---------------- scale to meters ----------------
    logic [30:0] theta_pos;
    logic [61:0] prod_reg;
    logic [61:0] prod_rnd;
    logic [25:0] dist_raw;
    logic [gcd_pkg::DIST_W-1:0] dist_reg;

    assign theta_pos = (theta < 0) ? '0 : theta[30:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 62'(theta_pos) * 62'(gcd_pkg::ARC_SCALE);
        end
    end

    assign prod_rnd = prod_reg + (62'(1) << 35);
    assign dist_raw = prod_rnd[61:36];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (dist_raw > 26'(gcd_pkg::MAX_DIST)) begin
                dist_reg <= gcd_pkg::MAX_DIST;
            end else begin
                dist_reg <= dist_raw[gcd_pkg::DIST_W-1:0];
            end
        end
    end

    assign m_tdata = {7'd0, dist_reg};

    // ---------------- assertions ----------------
    a_dist_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (dist_reg <= gcd_pkg::MAX_DIST))
        else $error("distance above half circumference");

    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_hav_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[A_IDX] |-> (a_reg <= gcd_pkg::Q_ONE))
        else $error("haversine term outside clamp range");

endmodule

// ===== hw/rtl/gcd_cordic.sv =====
// Pipelined CORDIC unit, rotation or vectoring mode, several iterations per stage.
`timescale 1ns / 1ps

module gcd_cordic #(
    parameter bit VECTORING = 1'b0
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [gcd_pkg::CW-1:0]  x_in,
    input  logic signed [gcd_pkg::CW-1:0]  y_in,
    input  logic signed [gcd_pkg::CW-1:0]  z_in,
    input  logic                           tag_in,
    output logic signed [gcd_pkg::CW-1:0]  x_out,
    output logic signed [gcd_pkg::CW-1:0]  y_out,
    output logic signed [gcd_pkg::CW-1:0]  z_out,
    output logic                           tag_out
);

    localparam int NS  = gcd_pkg::CORDIC_STAGES;
    localparam int SPS = gcd_pkg::CORDIC_SPS;
    localparam int W   = gcd_pkg::CW;

    logic signed [W-1:0] x_reg [NS];
    logic signed [W-1:0] y_reg [NS];
    logic signed [W-1:0] z_reg [NS];
    logic                tag_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic signed [W-1:0] x_i, y_i, z_i;
        logic signed [W-1:0] x_next, y_next, z_next;
        logic                tag_i;

        if (s == 0) begin : g_first
            assign x_i   = x_in;
            assign y_i   = y_in;
            assign z_i   = z_in;
            assign tag_i = tag_in;
        end else begin : g_rest
            assign x_i   = x_reg[s-1];
            assign y_i   = y_reg[s-1];
            assign z_i   = z_reg[s-1];
            assign tag_i = tag_reg[s-1];
        end

        always_comb begin
            logic signed [W-1:0] xt, yt, zt, dx, dy, t;
            logic                sel;
            xt = x_i;
            yt = y_i;
            zt = z_i;
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < gcd_pkg::STEPS) begin
                    dx  = yt >>> (s * SPS + j);
                    dy  = xt >>> (s * SPS + j);
                    t   = $signed(W'(gcd_pkg::ARC_TABLE[s * SPS + j]));
                    // sel: rotate toward positive angle
                    sel = VECTORING ? (yt < 0) : (zt >= 0);
                    if (sel) begin
                        xt = xt - dx;
                        yt = yt + dy;
                        zt = zt - t;
                    end else begin
                        xt = xt + dx;
                        yt = yt - dy;
                        zt = zt + t;
                    end
                end
            end
            x_next = xt;
            y_next = yt;
            z_next = zt;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]   <= x_next;
                y_reg[s]   <= y_next;
                z_reg[s]   <= z_next;
                tag_reg[s] <= tag_i;
            end
        end
    end

    assign x_out   = x_reg[NS-1];
    assign y_out   = y_reg[NS-1];
    assign z_out   = z_reg[NS-1];
    assign tag_out = tag_reg[NS-1];

endmodule

// ===== hw/rtl/gcd_isqrt.sv =====
// Pipelined integer square root, a few result bits per stage.
`timescale 1ns / 1ps

module gcd_isqrt (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [gcd_pkg::SQRT_IN_W-1:0]   v_in,
    output logic [gcd_pkg::ROOT_W-1:0]      root_out
);

    localparam int NS  = gcd_pkg::SQRT_STAGES;
    localparam int SPS = gcd_pkg::SQRT_SPS;
    localparam int VW  = gcd_pkg::SQRT_IN_W;
    localparam int RW  = gcd_pkg::RES_W;

    logic [VW-1:0] rem_reg [NS];
    logic [RW-1:0] res_reg [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [VW-1:0] rem_i, rem_next;
        logic [RW-1:0] res_i, res_next;

        if (s == 0) begin : g_first
            assign rem_i = v_in;
            assign res_i = '0;
        end else begin : g_rest
            assign rem_i = rem_reg[s-1];
            assign res_i = res_reg[s-1];
        end

        always_comb begin
            logic [VW-1:0] remt;
            logic [RW-1:0] rest, bitv, trial;
            remt = rem_i;
            rest = res_i;
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < gcd_pkg::SQRT_ITERS) begin
                    bitv  = RW'(1) << (VW - 1 - 2 * (s * SPS + j));
                    trial = rest + bitv;
                    if (RW'(remt) >= trial) begin
                        remt = remt - trial[VW-1:0];
                        rest = (rest >> 1) + bitv;
                    end else begin
                        rest = rest >> 1;
                    end
                end
            end
            rem_next = remt;
            res_next = rest;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                res_reg[s] <= res_next;
            end
        end
    end

    assign root_out = res_reg[NS-1][gcd_pkg::ROOT_W-1:0];

endmodule

// ===== tb/tb_great_circle_distance.sv =====
// Testbench for the haversine great-circle distance pipeline: table and random checks.
`timescale 1ns / 1ps

module tb_great_circle_distance;

    localparam int LAT_MAX  = 5898240;
    localparam int LON_MAX  = 11796480;
    localparam int N_RANDOM = 1850;
    localparam int WATCHDOG = 20000;
    localparam int NO_CHECK = -1;
    localparam int N_DIR    = 13;

    // one coordinate pair, fields at block widths
    typedef struct {
        logic signed [23:0] lat1;
        logic signed [24:0] lon1;
        logic signed [23:0] lat2;
        logic signed [24:0] lon2;
        int                 known;   // distance read off by hand, or NO_CHECK
    } pair_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;

    great_circle_distance u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [24:0] dist_queue [$];
    int          errors = 0;
    int          idle_pct_s = 0;
    int          idle_pct_m = 0;
    int          quiet = 0;

    const longint ARC_TAB [28] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
        115, 57, 29, 14, 7
    };

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // rotation CORDIC; angle in degrees * 2^24
    function automatic void rotate(input longint ang, output longint s, output longint c);
        longint r, x, y, z, dx, dy;
        bit neg;
        r = ang % (360 * 64'sd16777216);
        if (r < 0) r += 360 * 64'sd16777216;
        if (r >= 180 * 64'sd16777216) r -= 360 * 64'sd16777216;
        neg = 1'b0;
        if (r > 90 * 64'sd16777216) begin
            r = 180 * 64'sd16777216 - r; neg = 1'b1;
        end else if (r < -90 * 64'sd16777216) begin
            r = -180 * 64'sd16777216 - r; neg = 1'b1;
        end
        x = 652032874; y = 0; z = r;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARC_TAB[i];
            end else begin
                x += dx; y -= dy; z += ARC_TAB[i];
            end
        end
        s = y;
        c = neg ? -x : x;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [24:0] haversine_dist(pair_t p);
        longint sl, sn, c1, c2, unused, a, x, y, z, dx, dy;
        longint unsigned d;
        rotate((longint'(p.lat2) - longint'(p.lat1)) * 128, sl, unused);
        rotate((longint'(p.lon2) - longint'(p.lon1)) * 128, sn, unused);
        rotate(longint'(p.lat1) * 256, unused, c1);
        rotate(longint'(p.lat2) * 256, unused, c2);
        a = q30_mul(sl, sl) + q30_mul(q30_mul(c1, c2), q30_mul(sn, sn));
        if (a < 0) a = 0;
        if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
        x = int_sqrt(((64'd1 << 30) - a) << 30);
        y = int_sqrt(a << 30);
        z = 0;
        for (int i = 0; i < 28; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARC_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ARC_TAB[i];
            end
        end
        if (z < 0) z = 0;
        d = (longint'(z) * 64'd910908839 + (64'd1 << 35)) >> 36;
        if (d > 20015087) d = 20015087;
        return d[24:0];
    endfunction

    // append one expected distance to the scoreboard
    function automatic void expect_dist(logic [24:0] d);
        dist_queue = {dist_queue, d};
    endfunction

    // sender: holds the transaction until accepted; s_tvalid stays high
    // between back-to-back transactions
    task automatic send_pair(pair_t p);
        if ($urandom_range(99) < idle_pct_s) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct_s) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.lon2, p.lat2, p.lon1, p.lat1};
        if (p.known != NO_CHECK) expect_dist(p.known[24:0]);
        else expect_dist(haversine_dist(p));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // receiver and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (dist_queue.size() == 0) begin
                    $error("unexpected transaction, distance_meters %0d", m_tdata[24:0]);
                    errors++;
                end else begin
                    if (m_tdata[24:0] !== dist_queue[0]) begin
                        $error("distance_meters expected %0d actual %0d",
                               dist_queue[0], m_tdata[24:0]);
                        errors++;
                    end
                    void'(dist_queue.pop_front());
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct_m);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                    (dist_queue.size() == 0 && !s_tvalid)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic pair_t make_pair(int a, int b, int c, int d, int k);
        pair_t p;
        p.lat1 = 24'(a); p.lon1 = 25'(b); p.lat2 = 24'(c); p.lon2 = 25'(d); p.known = k;
        return p;
    endfunction

    function automatic int rnd_signed(int span, int bits);
        // mostly in range, sometimes any pattern of the field
        if ($urandom_range(9) == 0)
            return int'($urandom) <<< (32 - bits) >>> (32 - bits);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    pair_t dir_tab [N_DIR];
    pair_t p;

    initial begin
        // same point, antipodes, extremes, out-of-range wrap
        dir_tab[0]  = make_pair(0, 0, 0, 0, 0);
        dir_tab[1]  = make_pair(LAT_MAX, 0, LAT_MAX, 0, 0);
        dir_tab[2]  = make_pair(-LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, NO_CHECK);
        dir_tab[3]  = make_pair(LAT_MAX, 0, -LAT_MAX, 0, NO_CHECK);
        dir_tab[4]  = make_pair(0, 0, 0, LON_MAX, NO_CHECK);
        dir_tab[5]  = make_pair(0, -LON_MAX, 0, LON_MAX, NO_CHECK);
        dir_tab[6]  = make_pair(0, 0, 0, 1, NO_CHECK);
        dir_tab[7]  = make_pair(0, 0, 1, 0, NO_CHECK);
        dir_tab[8]  = make_pair(8388607, 16777215, -8388608, -16777216, NO_CHECK);
        dir_tab[9]  = make_pair(-8388608, -16777216, 8388607, 16777215, NO_CHECK);
        dir_tab[10] = make_pair(-1, -1, -1, -1, 0);
        dir_tab[11] = make_pair(3276800, 655360, -3276800, -LON_MAX + 655360, NO_CHECK);
        dir_tab[12] = make_pair(LAT_MAX, 0, LAT_MAX - 1, LON_MAX, NO_CHECK);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_pct_s = 10; idle_pct_m = 49;
        foreach (dir_tab[i]) send_pair(dir_tab[i]);
        s_tvalid <= 1'b0;
        // hold off until the pipe has drained
        while (dist_queue.size() != 0) @(posedge aclk);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                idle_pct_s = 49; idle_pct_m = 10;
            end else if (n == 2 * N_RANDOM / 3) begin
                idle_pct_s = 0; idle_pct_m = 0;
            end
            p.lat1 = 24'(rnd_signed(LAT_MAX, 24));
            p.lon1 = 25'(rnd_signed(LON_MAX, 25));
            if ($urandom_range(3) == 0) begin
                // close points
                p.lat2 = 24'(int'(p.lat1) + int'($urandom_range(2000)) - 1000);
                p.lon2 = 25'(int'(p.lon1) + int'($urandom_range(2000)) - 1000);
            end else begin
                p.lat2 = 24'(rnd_signed(LAT_MAX, 24));
                p.lon2 = 25'(rnd_signed(LON_MAX, 25));
            end
            p.known = NO_CHECK;
            send_pair(p);
        end
        s_tvalid <= 1'b0;
        while (dist_queue.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
